// File: design/rbsi_pkg.sv
// Shared types and constants for the ray versus box slab intersection unit.
// No dependencies; imported by every module of the block.
package rbsi_pkg;

   // Fixed-point word and derived widths
   localparam int Q_W           = 32;
   localparam int DIFF_W        = Q_W + 1;
   localparam int QUO_W         = 32;
   localparam int FRAC_BITS_DEF = 16;
   localparam int TOL_W         = 16;
   localparam int AXES          = 3;

   // Pipe depths: divider has a prep stage, one stage per quotient bit and a saturate stage
   localparam int DIV_LAT   = QUO_W + 2;
   localparam int LANE_LAT  = DIV_LAT + 2;
   localparam int MERGE_LAT = 2;
   localparam int PIPE_LAT  = LANE_LAT + MERGE_LAT;

   localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
   localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};
   localparam logic [TOL_W-1:0]      TOL_RESET = 16'd1;

   // What one axis lane reports to the merge stage
   typedef struct packed {
      logic                    inverted;  // box min above max on this axis
      logic                    near;      // direction counts as zero
      logic                    outside;   // near axis with origin outside slab
      logic signed [Q_W-1:0]   t_near;    // ordered entry distance
      logic signed [Q_W-1:0]   t_far;     // ordered exit distance
   } lane_out_type;

endpackage

// File: design/rbsi_div_pipe.sv
// Pipelined signed fixed-point divider: ((bound - origin) << FRAC_BITS) / dir,
// truncated toward zero and saturated to the Q range. Uses rbsi_pkg.
module rbsi_div_pipe import rbsi_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     enable,
   input  logic signed [DIFF_W-1:0] diff,
   input  logic [Q_W-1:0]           den_mag,
   input  logic                     den_neg,
   output logic signed [Q_W-1:0]    quotient
);

   localparam int NUM_W = DIFF_W + FRAC_BITS;
   localparam int W     = NUM_W + QUO_W;

   logic [W-1:0]     rem_ff [0:QUO_W];
   logic [QUO_W-1:0] quo_ff [0:QUO_W];
   logic [Q_W-1:0]   den_ff [0:QUO_W];
   logic             neg_ff [0:QUO_W];
   logic             ovf_ff [0:QUO_W];
   logic signed [Q_W-1:0] res_ff, res_in;

   logic [DIFF_W-1:0] diff_mag;
   logic [W-1:0]      num_mag;

   // Prep: magnitudes, quotient sign, overflow past the quotient width
   always_comb begin
      diff_mag = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
      num_mag  = W'(diff_mag) << FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0] <= num_mag;
         quo_ff[0] <= '0;
         den_ff[0] <= den_mag;
         neg_ff[0] <= diff[DIFF_W-1] ^ den_neg;
         ovf_ff[0] <= num_mag >= (W'(den_mag) << QUO_W);
      end
   end

   // One restoring step per quotient bit, most significant first
   for (genvar s = 0; s < QUO_W; s++) begin : g_bit
      localparam int BIT = QUO_W - 1 - s;
      logic [W-1:0]     shifted;
      logic             ge;
      logic [W-1:0]     rem_in;
      logic [QUO_W-1:0] quo_in;

      always_comb begin
         shifted = W'(den_ff[s]) << BIT;
         ge      = rem_ff[s] >= shifted;
         rem_in  = ge ? rem_ff[s] - shifted : rem_ff[s];
         quo_in  = quo_ff[s] | (QUO_W'(ge) << BIT);
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s+1] <= rem_in;
            quo_ff[s+1] <= quo_in;
            den_ff[s+1] <= den_ff[s];
            neg_ff[s+1] <= neg_ff[s];
            ovf_ff[s+1] <= ovf_ff[s];
         end
      end
   end

   // Apply sign and saturate
   always_comb begin
      if (ovf_ff[QUO_W]) begin
         res_in = neg_ff[QUO_W] ? Q_MIN : Q_MAX;
      end else if (neg_ff[QUO_W]) begin
         res_in = (quo_ff[QUO_W] > QUO_W'(Q_MIN)) ? Q_MIN : Q_W'(-quo_ff[QUO_W]);
      end else begin
         res_in = quo_ff[QUO_W][QUO_W-1] ? Q_MAX : Q_W'(quo_ff[QUO_W]);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) res_ff <= res_in;
   end

   assign quotient = res_ff;

endmodule

// File: design/rbsi_axis_lane.sv
// One axis of the slab test: bound checks, two pipelined divisions, ordering.
// Depends on rbsi_pkg and rbsi_div_pipe.
module rbsi_axis_lane import rbsi_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  enable,
   input  logic [TOL_W-1:0]      tolerance,
   input  logic signed [Q_W-1:0] origin,
   input  logic signed [Q_W-1:0] dir,
   input  logic signed [Q_W-1:0] box_min,
   input  logic signed [Q_W-1:0] box_max,
   output lane_out_type          result
);

   logic signed [DIFF_W-1:0] dlo_ff, dhi_ff;
   logic [Q_W-1:0]           dmag_ff, dmag_in;
   logic                     dneg_ff;
   logic                     inv_ff [0:DIV_LAT];
   logic                     near_ff [0:DIV_LAT];
   logic                     out_ff [0:DIV_LAT];
   logic signed [Q_W-1:0]    t1, t2;
   lane_out_type             res_ff, res_in;

   assign dmag_in = dir[Q_W-1] ? Q_W'(-dir) : Q_W'(dir);

   // Front stage: differences, direction magnitude and slab flags
   always_ff @(posedge clock) begin
      if (enable) begin
         dlo_ff     <= {box_min[Q_W-1], box_min} - {origin[Q_W-1], origin};
         dhi_ff     <= {box_max[Q_W-1], box_max} - {origin[Q_W-1], origin};
         dmag_ff    <= dmag_in;
         dneg_ff    <= dir[Q_W-1];
         inv_ff[0]  <= box_min > box_max;
         near_ff[0] <= dmag_in <= Q_W'(tolerance);
         out_ff[0]  <= (origin < box_min) || (origin > box_max);
      end
   end

   // Flags ride alongside the dividers
   for (genvar i = 0; i < DIV_LAT; i++) begin : g_side
      always_ff @(posedge clock) begin
         if (enable) begin
            inv_ff[i+1]  <= inv_ff[i];
            near_ff[i+1] <= near_ff[i];
            out_ff[i+1]  <= out_ff[i];
         end
      end
   end

   rbsi_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
      .clock(clock), .enable(enable), .diff(dlo_ff),
      .den_mag(dmag_ff), .den_neg(dneg_ff), .quotient(t1)
   );

   rbsi_div_pipe #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
      .clock(clock), .enable(enable), .diff(dhi_ff),
      .den_mag(dmag_ff), .den_neg(dneg_ff), .quotient(t2)
   );

   // Order entry and exit
   always_comb begin
      res_in.inverted = inv_ff[DIV_LAT];
      res_in.near     = near_ff[DIV_LAT];
      res_in.outside  = near_ff[DIV_LAT] && out_ff[DIV_LAT];
      res_in.t_near   = (t1 > t2) ? t2 : t1;
      res_in.t_far    = (t1 > t2) ? t1 : t2;
   end

   always_ff @(posedge clock) begin
      if (enable) res_ff <= res_in;
   end

   assign result = res_ff;

endmodule

// File: design/rbsi_merge.sv
// Merges the three axis lanes into the hit flag and distance.
// Depends on rbsi_pkg.
module rbsi_merge import rbsi_pkg::*; (
   input  logic                  clock,
   input  logic                  enable,
   input  lane_out_type          lanes [AXES],
   output logic                  hit,
   output logic [Q_W-2:0]        hit_distance
);

   logic signed [Q_W-1:0] lo_ff, hi_ff, lo_in, hi_in;
   logic                  fail_ff, fail_in;
   logic                  hit_ff, hit_in;
   logic [Q_W-2:0]        dist_ff, dist_in;

   // Interval: max of entries, min of exits over non-near axes
   always_comb begin
      lo_in   = Q_MIN;
      hi_in   = Q_MAX;
      fail_in = 1'b0;
      for (int a = 0; a < AXES; a++) begin
         fail_in = fail_in | lanes[a].inverted | lanes[a].outside;
         if (!lanes[a].near) begin
            if (lanes[a].t_near > lo_in) lo_in = lanes[a].t_near;
            if (lanes[a].t_far < hi_in)  hi_in = lanes[a].t_far;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         fail_ff <= fail_in;
      end
   end

   // Decision and distance
   always_comb begin
      hit_in  = !fail_ff && (lo_ff <= hi_ff) && !hi_ff[Q_W-1];
      dist_in = '0;
      if (hit_in) dist_in = lo_ff[Q_W-1] ? hi_ff[Q_W-2:0] : lo_ff[Q_W-2:0];
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         hit_ff  <= hit_in;
         dist_ff <= dist_in;
      end
   end

   assign hit          = hit_ff;
   assign hit_distance = dist_ff;

endmodule

// File: design/ray_box_slab_intersect_unit.sv
// Top level of the ray versus axis-aligned box slab test.
// Depends on rbsi_pkg, rbsi_axis_lane and rbsi_merge.
//
//   channel  ports        direction  contents
//   req      req_*        in         ray origin, direction, box corners
//   rsp      rsp_*        out        hit flag and hit distance
//   csr      csr_*        in         zero tolerance, written without wait
//
// One request per cycle while the pipe advances; each result passes through the
// 32 quotient-bit stages of each lane's dividers plus the lane and merge stages.
// The whole pipe advances whenever the result register is empty or taken.
// A stalled result holds the pipe; bubbles travel through it unchanged.
// Synchronous reset clears the valid line and sets the tolerance to 1.
module ray_box_slab_intersect_unit import rbsi_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [TOL_W-1:0]      csr_write_data,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [Q_W-1:0] req_origin_x,
   input  logic signed [Q_W-1:0] req_origin_y,
   input  logic signed [Q_W-1:0] req_origin_z,
   input  logic signed [Q_W-1:0] req_dir_x,
   input  logic signed [Q_W-1:0] req_dir_y,
   input  logic signed [Q_W-1:0] req_dir_z,
   input  logic signed [Q_W-1:0] req_box_min_x,
   input  logic signed [Q_W-1:0] req_box_min_y,
   input  logic signed [Q_W-1:0] req_box_min_z,
   input  logic signed [Q_W-1:0] req_box_max_x,
   input  logic signed [Q_W-1:0] req_box_max_y,
   input  logic signed [Q_W-1:0] req_box_max_z,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_hit,
   output logic [Q_W-2:0]        rsp_hit_distance
);

   logic [TOL_W-1:0]    tol_ff;
   logic [PIPE_LAT-1:0] vld_ff, vld_in;
   logic                advance;
   lane_out_type        lanes [AXES];
   logic signed [Q_W-1:0] org [AXES], dir [AXES], bmin [AXES], bmax [AXES];

   assign org  = '{req_origin_x, req_origin_y, req_origin_z};
   assign dir  = '{req_dir_x, req_dir_y, req_dir_z};
   assign bmin = '{req_box_min_x, req_box_min_y, req_box_min_z};
   assign bmax = '{req_box_max_x, req_box_max_y, req_box_max_z};

   // Tolerance register
   always_ff @(posedge clock) begin
      if (reset) tol_ff <= TOL_RESET;
      else if (csr_write_enable) tol_ff <= csr_write_data;
   end

   // Global pipe advance and valid line
   assign advance   = !vld_ff[PIPE_LAT-1] || rsp_ready;
   assign req_ready = advance;
   assign vld_in    = {vld_ff[PIPE_LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= '0;
      else if (advance) vld_ff <= vld_in;
   end

   for (genvar a = 0; a < AXES; a++) begin : g_lane
      rbsi_axis_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
         .clock(clock), .enable(advance), .tolerance(tol_ff),
         .origin(org[a]), .dir(dir[a]), .box_min(bmin[a]), .box_max(bmax[a]),
         .result(lanes[a])
      );
   end

   rbsi_merge u_merge (
      .clock(clock), .enable(advance), .lanes(lanes),
      .hit(rsp_hit), .hit_distance(rsp_hit_distance)
   );

   assign rsp_valid = vld_ff[PIPE_LAT-1];

   // A miss always reports zero distance
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_hit) |-> (rsp_hit_distance == '0))
      else $error("miss with nonzero distance");

   // Pipe holds its valid line while the result is stalled
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(vld_ff))
      else $error("valid line moved during stall");

   // An accepted request enters the first pipe stage
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted request lost");

endmodule
